// ===== sv/eiu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eiu_pkg
// shared types and constants of the external pin interrupt unit
// ----------------------------------------------------------------------------
package eiu_pkg;

    localparam int NUM_LINES   = 2;
    localparam int DATA_W      = 8;
    localparam int SENSE_W     = 2 * NUM_LINES;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 16;

    // register address on the bus
    localparam logic REG_MASK = 1'b0;
    localparam logic REG_FLAG = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_ACK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SENSE_LOW  = 2'd0,
        SENSE_ANY  = 2'd1,
        SENSE_FALL = 2'd2,
        SENSE_RISE = 2'd3
    } t_sense;

    typedef struct packed {
        t_func                  func;
        logic [NUM_LINES-1:0]   pin_levels;
        logic                   reg_select;
        logic [DATA_W-1:0]      write_data;
        logic                   ack_line;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]      read_data;
        logic [NUM_LINES-1:0]   irq_request;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/eiu_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eiu_state
// sense control, mask, flag and previous pin registers with item update logic
// ----------------------------------------------------------------------------
module eiu_state
    import eiu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [SENSE_W-1:0]   i_cfg_data,
    input  wire logic                 i_item_valid,
    input  wire t_item                i_item,
    output t_result                   o_result
);

    logic [SENSE_W-1:0]   r_sense;
    logic [NUM_LINES-1:0] r_mask, n_mask;
    logic [NUM_LINES-1:0] r_flag, n_flag;
    logic [NUM_LINES-1:0] r_prev, n_prev;
    logic [DATA_W-1:0]    w_rd;

    always_comb begin
        n_mask = r_mask;
        n_flag = r_flag;
        n_prev = r_prev;
        w_rd   = '0;
        case (i_item.func)
            FUNC_TICK: begin
                for (int n = 0; n < NUM_LINES; n++) begin
                    case (t_sense'(r_sense[2*n +: 2]))
                        SENSE_LOW: n_flag[n] = ~i_item.pin_levels[n];
                        SENSE_ANY: begin
                            if (i_item.pin_levels[n] != r_prev[n]) n_flag[n] = 1'b1;
                        end
                        SENSE_FALL: begin
                            if (!i_item.pin_levels[n] && r_prev[n]) n_flag[n] = 1'b1;
                        end
                        SENSE_RISE: begin
                            if (i_item.pin_levels[n] && !r_prev[n]) n_flag[n] = 1'b1;
                        end
                        default: n_flag[n] = r_flag[n];
                    endcase
                end
                n_prev = i_item.pin_levels;
            end
            FUNC_WRITE: begin
                if (i_item.reg_select == REG_MASK) begin
                    n_mask = i_item.write_data[NUM_LINES-1:0];
                end else begin
                    // ones clear flags
                    n_flag = r_flag & ~i_item.write_data[NUM_LINES-1:0];
                end
            end
            FUNC_READ: begin
                if (i_item.reg_select == REG_FLAG) begin
                    w_rd = {{(DATA_W-NUM_LINES){1'b0}}, r_flag};
                end else begin
                    w_rd = {{(DATA_W-NUM_LINES){1'b0}}, r_mask};
                end
            end
            FUNC_ACK: begin
                n_flag[i_item.ack_line] = 1'b0;
            end
            default: n_flag = r_flag;
        endcase
    end

    assign o_result.read_data   = w_rd;
    assign o_result.irq_request = n_mask & n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense <= '0;
            r_mask  <= '0;
            r_flag  <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sense <= i_cfg_data;
            end
            if (i_item_valid) begin
                r_mask <= n_mask;
                r_flag <= n_flag;
                r_prev <= n_prev;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/external_pin_interrupt_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// external_pin_interrupt_unit
// two-line external interrupt unit with mask, flag and sense registers
// ----------------------------------------------------------------------------
// path: an item passes the input register, the state update, then the result register,
// and waits in the input register while the result slot is blocked
// throughput: one item per cycle while the result stream is not stalled
// reset: synchronous active low; clears sense, mask, flags, previous pins
// and both valid bits, so no result is pending after reset
// ----------------------------------------------------------------------------
module external_pin_interrupt_unit
    import eiu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sense control write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [SENSE_W-1:0]    i_cfg_data,
    // input item stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: pin_levels[1:0], write_data[9:2], ack_line[10], zero [15:11]
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // tuser: func[1:0], reg_select[2]
    input  wire logic [S_TUSER_W-1:0]  i_s_tuser,
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata: read_data[7:0], irq_request[9:8], zero [15:10]
    output logic [M_TDATA_W-1:0]       o_m_tdata
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_out_free;
    logic    w_process;

    // result slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_process  = r_in_valid && w_out_free;

    // input register takes a new item when empty or whenever its content moves on
    assign o_s_tready  = !r_in_valid || w_out_free;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.func       <= t_func'(i_s_tuser[1:0]);
            r_in.reg_select <= i_s_tuser[2];
            r_in.pin_levels <= i_s_tdata[1:0];
            r_in.write_data <= i_s_tdata[9:2];
            r_in.ack_line   <= i_s_tdata[10];
        end
    end

    // state registers and update logic; item updates commit only as the item moves on
    eiu_state u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_process),
        .i_item       (r_in),
        .o_result     (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-DATA_W-NUM_LINES){1'b0}},
                         r_out.irq_request, r_out.read_data};

    // an item leaving the input register always lands in the result register
    a_process_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> r_out_valid)
        else $error("processed item did not reach the result register");

    // only a read can return nonzero data
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_process && r_in.func != FUNC_READ) |=> (r_out.read_data == '0))
        else $error("nonzero read data on a non-read item");

    // read data never carries bits above the two line bits
    a_read_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.read_data[DATA_W-1:NUM_LINES] == '0))
        else $error("read data upper bits set");

    // a held input item is not overwritten while the result slot is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed while stalled");

endmodule
`default_nettype wire
